@@ rtl/core/wtdc_pkg.sv @@
// ----------------------------------------------------------------------------
// wtdc_pkg: shared types and constants of the waypoint controller
// Sequencer states, register indexes, fixed-point constants, the CORDIC
// arctangent table and the output saturation helper.
// ----------------------------------------------------------------------------
package wtdc_pkg;

  // Fixed-point constants. Angles on the ports are Q3.13, CORDIC angles Q2.29.
  localparam int unsigned ANG_W   = 18;  // heading error width, holds a wrapped sum
  localparam int unsigned DIST_W  = 35;  // distance in Q16.16 raw units
  localparam int unsigned PROD_W  = 56;  // multiplier result kept in prod_q
  localparam int unsigned XY_W    = 36;  // CORDIC x and y datapath
  localparam int unsigned Z_W     = 33;  // CORDIC angle accumulator

  localparam logic signed [ANG_W-1:0] PiQ13    = 18'sd25736;
  localparam logic signed [ANG_W-1:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [Z_W-1:0]   HalfPiQ29 = 33'sd843314857;
  localparam logic signed [Z_W-1:0]   RoundQ16  = 33'sd32768;
  localparam logic [31:0]             InvGainQ32 = 32'd2608131496;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PRE    = 9'b000000010,
    ST_ITER   = 9'b000000100,
    ST_MAG_HI = 9'b000001000,
    ST_MAG_LO = 9'b000010000,
    ST_DIST   = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_SCALE  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  // Register map, word index on the configuration port.
  typedef enum logic [2:0] {
    REG_TURN_GAIN  = 3'd0,
    REG_DRIVE_GAIN = 3'd1,
    REG_DIST_LEAVE = 3'd2,
    REG_DIST_ARRIVE = 3'd3,
    REG_ANG_LEAVE  = 3'd4,
    REG_ANG_ARRIVE = 3'd5,
    REG_FINAL_TOL  = 3'd6
  } reg_idx_e;

  // Opcodes carried on the input tuser.
  typedef enum logic {
    OP_SET_GOAL = 1'b0,
    OP_STEP     = 1'b1
  } opcode_e;

  // atan(2^-i) in Q2.29, rounded.
  function automatic logic [30:0] atan_q29(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:  r = 31'd421657428;
      5'd1:  r = 31'd248918915;
      5'd2:  r = 31'd131521918;
      5'd3:  r = 31'd66762579;
      5'd4:  r = 31'd33510843;
      5'd5:  r = 31'd16771758;
      5'd6:  r = 31'd8387925;
      5'd7:  r = 31'd4194219;
      5'd8:  r = 31'd2097141;
      5'd9:  r = 31'd1048575;
      5'd10: r = 31'd524288;
      5'd11: r = 31'd262144;
      5'd12: r = 31'd131072;
      5'd13: r = 31'd65536;
      5'd14: r = 31'd32768;
      5'd15: r = 31'd16384;
      5'd16: r = 31'd8192;
      5'd17: r = 31'd4096;
      5'd18: r = 31'd2048;
      5'd19: r = 31'd1024;
      5'd20: r = 31'd512;
      5'd21: r = 31'd256;
      5'd22: r = 31'd128;
      5'd23: r = 31'd64;
      5'd24: r = 31'd32;
      5'd25: r = 31'd16;
      5'd26: r = 31'd8;
      5'd27: r = 31'd4;
      5'd28: r = 31'd2;
      5'd29: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  // Clamp a signed product to the int32 range.
  function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-32:0] hi;
    logic [31:0]        r;
    hi = v[PROD_W-1:31];
    if ((&hi) || (~|hi)) begin
      r = v[31:0];
    end else if (v[PROD_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/waypoint_turn_then_drive_controller_core.sv @@
// ----------------------------------------------------------------------------
// waypoint_turn_then_drive_controller_core: go-to-goal pose controller
// A beat with tuser 0 stores a goal pose and arms the waypoint; it yields no
// result. A beat with tuser 1 is one control step on the current pose and, if
// a goal has been set, yields one result beat with the linear and angular
// velocity commands (Q16.16, saturated) and the waypoint_active and
// target_achieved flags; a step before any goal is dropped without a result.
// A control step occupies the block from acceptance until it is ready again:
// a pre-rotation, then the single CORDIC rotator that runs one iteration per
// cycle, followed by a shared multiplier used three times (two halves of the
// gain correction, then the velocity gain). The result sits in an output
// register, so the next beat is accepted while it waits; the sequencer only
// stalls in its last state if the previous result is still untaken.
// Configuration is an APB-style port with seven registers at byte addresses
// 4*i; pready is always high.
// ----------------------------------------------------------------------------
module waypoint_turn_then_drive_controller_core #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: coord_x [31:0], coord_y [63:32], angle [79:64].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,
  // tuser: opcode [0].
  input  logic [0:0]  s_axis_tuser_i,
  // Result stream. tdata: linear_velocity [31:0], angular_velocity [63:32],
  // waypoint_active [64], target_achieved [65], zero fill [71:66].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import wtdc_pkg::*;

  // Iteration counter counts 0 .. CORDIC_ITERATIONS-1 through the iterations.
  localparam int unsigned IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] turn_gain_q, drive_gain_q;
  logic [31:0] dist_leave_q, dist_arrive_q;
  logic [14:0] ang_leave_q, ang_arrive_q, final_tol_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q   <= 16'd5734;
      drive_gain_q  <= 16'd10813;
      dist_leave_q  <= 32'd3277;
      dist_arrive_q <= 32'd1966;
      ang_leave_q   <= 15'd1229;
      ang_arrive_q  <= 15'd819;
      final_tol_q   <= 15'd410;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TURN_GAIN:   turn_gain_q   <= pwdata[15:0];
        REG_DRIVE_GAIN:  drive_gain_q  <= pwdata[15:0];
        REG_DIST_LEAVE:  dist_leave_q  <= pwdata;
        REG_DIST_ARRIVE: dist_arrive_q <= pwdata;
        REG_ANG_LEAVE:   ang_leave_q   <= pwdata[14:0];
        REG_ANG_ARRIVE:  ang_arrive_q  <= pwdata[14:0];
        REG_FINAL_TOL:   final_tol_q   <= pwdata[14:0];
        default: ;  // Unmapped index: the write is dropped.
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TURN_GAIN:   prdata = {16'd0, turn_gain_q};
      REG_DRIVE_GAIN:  prdata = {16'd0, drive_gain_q};
      REG_DIST_LEAVE:  prdata = dist_leave_q;
      REG_DIST_ARRIVE: prdata = dist_arrive_q;
      REG_ANG_LEAVE:   prdata = {17'd0, ang_leave_q};
      REG_ANG_ARRIVE:  prdata = {17'd0, ang_arrive_q};
      REG_FINAL_TOL:   prdata = {17'd0, final_tol_q};
      default:         prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input beat decode
  // --------------------------------------------------------------------------
  logic signed [31:0] in_x, in_y;
  logic signed [15:0] in_ang;
  logic               in_acc;
  opcode_e            in_op;

  assign in_x   = s_axis_tdata_i[31:0];
  assign in_y   = s_axis_tdata_i[63:32];
  assign in_ang = s_axis_tdata_i[79:64];
  assign in_op  = opcode_e'(s_axis_tuser_i[0]);
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  // Goal pose and controller flags.
  logic signed [31:0] goal_x_q, goal_y_q;
  logic signed [15:0] goal_h_q;
  logic goal_valid_q, active_q, loc_met_q, ang_met_q;
  logic active_d, loc_met_d, ang_met_d;

  // Datapath registers for one control step.
  logic signed [15:0]       head_q;
  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic [IterW-1:0]         iter_q, iter_d;
  logic                     zero_q, zero_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0]        acc_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [ANG_W-1:0]  err_q, used_q;
  logic                     turn_q, drive_q, achieved_q;

  // Output register.
  logic        out_valid_q, out_valid_d, out_load;
  logic [31:0] lin_q, ang_q;
  logic        wp_active_q, tgt_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, tgt_q, wp_active_q, ang_q, lin_q};

  // --------------------------------------------------------------------------
  // Goal offset, CORDIC rotator and pre-rotation
  // --------------------------------------------------------------------------
  logic signed [32:0]     dx, dy;
  logic signed [XY_W-1:0] x_sh, y_sh;
  logic signed [Z_W-1:0]  atan_ext;

  assign dx = 33'(goal_x_q) - 33'(in_x);
  assign dy = 33'(goal_y_q) - 33'(in_y);

  // Shared shifters: one vectoring iteration per cycle, index from the counter.
  assign x_sh     = x_q >>> iter_q;
  assign y_sh     = y_q >>> iter_q;
  assign atan_ext = $signed({2'b00, atan_q29(5'(iter_q))});

  // --------------------------------------------------------------------------
  // Magnitude, bearing and heading error
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0]       mag;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [16:0]      bearing;
  logic signed [ANG_W-1:0] err_raw, err_w1, err_w2;
  logic [PROD_W-1:0]       dist_sum;

  assign mag     = (x_q > 0) ? x_q[DIST_W-1:0] : '0;
  assign z_rnd   = z_q + RoundQ16;
  // Bearing is the rounded Q3.13 angle; a zero offset has bearing zero.
  assign bearing = zero_q ? 17'sd0 : z_rnd[32:16];
  assign err_raw = ANG_W'(bearing) - ANG_W'(head_q);
  assign err_w1  = (err_raw > PiQ13) ? (err_raw - TwoPiQ13) : err_raw;
  assign err_w2  = (err_w1 < -PiQ13) ? (err_w1 + TwoPiQ13) : err_w1;
  assign dist_sum = acc_q + {16'd0, prod_q[PROD_W-1:16]};

  // --------------------------------------------------------------------------
  // Decision logic (hysteresis, mode select, disarm)
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0] final_err, used;
  logic [ANG_W-1:0]        used_abs, final_abs;
  logic dist_far, dist_near, loc1, ang1, turn, drive, loc2, reached;

  assign final_err = ANG_W'(goal_h_q) - ANG_W'(head_q);
  assign dist_far  = (dist_q >= DIST_W'(dist_leave_q));
  assign dist_near = (dist_q <  DIST_W'(dist_arrive_q));
  assign loc1      = dist_far ? 1'b0 : (dist_near ? 1'b1 : loc_met_q);
  assign used      = loc1 ? final_err : err_q;
  assign used_abs  = used[ANG_W-1] ? ANG_W'(-used) : ANG_W'(used);
  assign final_abs = final_err[ANG_W-1] ? ANG_W'(-final_err) : ANG_W'(final_err);
  assign ang1      = (used_abs > ANG_W'(ang_leave_q)) ? 1'b0 :
                     ((used_abs < ANG_W'(ang_arrive_q)) ? 1'b1 : ang_met_q);
  assign turn      = active_q & ~ang1;
  assign drive     = ~turn & active_q & dist_far & ~loc1;
  // With neither turning nor driving, the position counts as met.
  assign loc2      = (turn | drive) ? loc1 : 1'b1;
  assign reached   = loc2 & (final_abs < ANG_W'(final_tol_q));

  // --------------------------------------------------------------------------
  // Shared multiplier: gain correction halves, then the velocity gain
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] mul_a;
  logic [31:0]            mul_b;
  logic signed [68:0]     mul_full;

  always_comb begin
    mul_a = '0;
    mul_b = InvGainQ32;
    case (state_q)
      ST_MAG_HI: mul_a = {17'd0, mag[DIST_W-1:16]};
      ST_MAG_LO: mul_a = {20'd0, mag[15:0]};
      ST_SCALE: begin
        if (turn_q) begin
          mul_a = XY_W'(used_q);
          mul_b = {16'd0, turn_gain_q};
        end else begin
          mul_a = {1'b0, dist_q};
          mul_b = {16'd0, drive_gain_q};
        end
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    iter_d      = iter_q;
    zero_d      = zero_q;
    prod_d      = prod_q;
    active_d    = active_q;
    loc_met_d   = loc_met_q;
    ang_met_d   = ang_met_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_STEP && goal_valid_q) begin
          x_d     = XY_W'(dx);
          y_d     = XY_W'(dy);
          state_d = ST_PRE;
        end else if (in_acc && in_op == OP_SET_GOAL) begin
          active_d = 1'b1;
        end
      end
      ST_PRE: begin
        // Rotate the offset into the right half plane.
        zero_d = (x_q == '0) && (y_q == '0);
        iter_d = '0;
        if (x_q >= 0) begin
          z_d = '0;
        end else if (y_q >= 0) begin
          x_d = y_q;
          y_d = -x_q;
          z_d = HalfPiQ29;
        end else begin
          x_d = -y_q;
          y_d = x_q;
          z_d = -HalfPiQ29;
        end
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (y_q > 0) begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + atan_ext;
        end else begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - atan_ext;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          state_d = ST_MAG_HI;
        end
      end
      ST_MAG_HI: begin
        prod_d  = mul_full[PROD_W-1:0];
        state_d = ST_MAG_LO;
      end
      ST_MAG_LO: begin
        prod_d  = mul_full[PROD_W-1:0];
        state_d = ST_DIST;
      end
      ST_DIST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        ang_met_d = ang1;
        loc_met_d = loc2;
        if (reached) begin
          active_d = 1'b0;
        end
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        prod_d  = mul_full[PROD_W-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold here only while the previous result is still untaken.
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready_i);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      goal_valid_q <= 1'b0;
      active_q     <= 1'b0;
      loc_met_q    <= 1'b1;
      ang_met_q    <= 1'b1;
      out_valid_q  <= 1'b0;
      iter_q       <= '0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_h_q     <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      loc_met_q   <= loc_met_d;
      ang_met_q   <= ang_met_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      if (in_acc && in_op == OP_SET_GOAL) begin
        goal_x_q     <= in_x;
        goal_y_q     <= in_y;
        goal_h_q     <= in_ang;
        goal_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
    prod_q <= prod_d;
    if (in_acc) begin
      head_q <= in_ang;
    end
    if (state_q == ST_MAG_LO) begin
      acc_q <= prod_q;
      err_q <= err_w2;
    end
    if (state_q == ST_DIST) begin
      dist_q <= dist_sum[DIST_W+15:16];
    end
    if (state_q == ST_DECIDE) begin
      used_q     <= used;
      turn_q     <= turn;
      drive_q    <= drive;
      achieved_q <= reached & active_q;
    end
    if (out_load) begin
      lin_q       <= drive_q ? sat32(prod_q >>> 14) : 32'd0;
      ang_q       <= turn_q ? sat32(prod_q >>> 11) : 32'd0;
      wp_active_q <= active_q;
      tgt_q       <= achieved_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A result appears only out of the final sequencer state.
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");

  // A control step with a stored goal always starts the CORDIC sequence.
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == OP_STEP && goal_valid_q) |=> (state_q == ST_PRE))
    else $error("accepted control step did not start the sequence");

  // Turning and driving are mutually exclusive.
  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE) |-> !(turn_q && drive_q))
    else $error("turn and drive selected together");

  // A step that reaches the target always disarms the waypoint.
  a_achieved_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tgt_q) |-> !wp_active_q)
    else $error("target achieved while the waypoint is still active");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the waypoint turn-then-drive controller
// Goal and control-step beats go in on the input stream. A behavioral copy
// of the controller, with its own goal, flag and tuning state, predicts
// each velocity command. The result stream is checked field by field
// against those predictions, in order. Tuning registers are rewritten
// between phases while the block is idle, and both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import wtdc_pkg::*;

  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned IdlePercent  = 9;
  // Longer than one control step.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PrintCap     = 50;
  localparam longint      CycleLimit   = 400000;
  localparam logic [2:0]  UnmappedReg  = 3'd7;

  localparam longint          PiRad         = 25736;
  localparam longint          HalfPiRadQ29  = 843314857;
  localparam longint unsigned InvCordicGain = 64'd2608131496;

  typedef struct packed {
    logic [31:0] linear;
    logic [31:0] angular;
    logic        active;
    logic        achieved;
  } drive_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i;   // coord_x [31:0], coord_y [63:32], angle [79:64]
  logic [0:0]  s_axis_tuser_i;   // opcode [0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // linear_velocity [31:0], angular_velocity [63:32], waypoint_active [64],
  // target_achieved [65], zero fill [71:66]
  logic [71:0] m_axis_tdata_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // atan(2^-i) in Q2.29 radians.
  longint atan_q29_tab [32] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1, 0, 0
  };

  // Tuning registers as the bench believes them to be.
  logic [15:0] tune_turn_gain;
  logic [15:0] tune_drive_gain;
  logic [31:0] tune_dist_leave;
  logic [31:0] tune_dist_arrive;
  logic [14:0] tune_ang_leave;
  logic [14:0] tune_ang_arrive;
  logic [14:0] tune_final_tol;

  // Navigation state of the behavioral copy.
  longint nav_goal_x;
  longint nav_goal_y;
  longint nav_goal_heading;
  logic   nav_goal_valid;
  logic   nav_armed;
  logic   nav_at_location;
  logic   nav_aligned;

  drive_cmd_t  pending_commands [$];
  logic        no_idle;
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  int unsigned mismatch_count  = 0;
  longint      cycle_count     = 0;

  waypoint_turn_then_drive_controller_core #(
    .CORDIC_ITERATIONS(CordicSteps)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Behavioral copy of the controller
  // ---------------------------------------------------------------------------

  function automatic void restore_power_on_state();
    tune_turn_gain   = 16'd5734;
    tune_drive_gain  = 16'd10813;
    tune_dist_leave  = 32'd3277;
    tune_dist_arrive = 32'd1966;
    tune_ang_leave   = 15'd1229;
    tune_ang_arrive  = 15'd819;
    tune_final_tol   = 15'd410;
    nav_goal_x       = 0;
    nav_goal_y       = 0;
    nav_goal_heading = 0;
    nav_goal_valid   = 1'b0;
    nav_armed        = 1'b0;
    nav_at_location  = 1'b1;
    nav_aligned      = 1'b1;
  endfunction

  function automatic logic [31:0] clamp_int32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // One vectoring pass: range in Q16.16 raw units, bearing in Q3.13.
  function automatic void cordic_vectoring(input longint dx, input longint dy,
                                           output longint unsigned range_q16,
                                           output longint bearing);
    longint          x;
    longint          y;
    longint          z;
    longint          nx;
    longint unsigned mag;
    int              i;
    if (dx == 0 && dy == 0) begin
      range_q16 = 0;
      bearing   = 0;
      return;
    end
    // Pre-rotate by a quarter turn so the vector starts in the right half.
    if (dx >= 0) begin
      x = dx;  y = dy;  z = 0;
    end else if (dy >= 0) begin
      x = dy;  y = -dx; z = HalfPiRadQ29;
    end else begin
      x = -dy; y = dx;  z = -HalfPiRadQ29;
    end
    for (i = 0; i < CordicSteps && i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_q29_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_q29_tab[i];
      end
      x = nx;
    end
    mag = (x > 0) ? x : 0;
    // Gain correction split in two halves so nothing overflows 64 bits.
    range_q16 = (((mag >> 16) * InvCordicGain) +
                 (((mag & 64'hFFFF) * InvCordicGain) >> 16)) >> 16;
    bearing = (z + 32768) >>> 16;
  endfunction

  // Applies one accepted input beat and queues the command it produces.
  function automatic void predict_drive_command(input opcode_e op, input logic [31:0] x,
                                                input logic [31:0] y,
                                                input logic [15:0] hdg);
    longint          px;
    longint          py;
    longint          ph;
    longint          bearing;
    longint          err;
    longint          final_err;
    longint          used;
    longint          used_mag;
    longint          final_mag;
    longint          lin;
    longint          ang;
    longint unsigned range_q16;
    logic            was_armed;
    drive_cmd_t      cmd;
    px = longint'($signed(x));
    py = longint'($signed(y));
    ph = longint'($signed(hdg));
    if (op == OP_SET_GOAL) begin
      nav_goal_x       = px;
      nav_goal_y       = py;
      nav_goal_heading = ph;
      nav_goal_valid   = 1'b1;
      nav_armed        = 1'b1;
      return;
    end
    if (!nav_goal_valid) begin
      return;
    end
    was_armed    = nav_armed;
    cmd.achieved = 1'b0;
    lin = 0;
    ang = 0;
    cordic_vectoring(nav_goal_x - px, nav_goal_y - py, range_q16, bearing);
    // The bearing error wraps once; the final heading error never does.
    err = bearing - ph;
    if (err > PiRad) err = err - 2 * PiRad;
    if (err < -PiRad) err = err + 2 * PiRad;
    final_err = nav_goal_heading - ph;

    if (range_q16 >= tune_dist_leave) begin
      nav_at_location = 1'b0;
    end else if (range_q16 < tune_dist_arrive) begin
      nav_at_location = 1'b1;
    end
    used     = nav_at_location ? final_err : err;
    used_mag = (used < 0) ? -used : used;
    if (used_mag > tune_ang_leave) begin
      nav_aligned = 1'b0;
    end else if (used_mag < tune_ang_arrive) begin
      nav_aligned = 1'b1;
    end

    if (nav_armed && !nav_aligned) begin
      ang = (longint'(tune_turn_gain) * used) >>> 11;
    end else if (nav_armed && range_q16 >= tune_dist_leave && !nav_at_location) begin
      lin = longint'((range_q16 * tune_drive_gain) >> 14);
    end else begin
      // Neither turning nor driving: treat the position as reached.
      nav_at_location = 1'b1;
    end

    final_mag = (final_err < 0) ? -final_err : final_err;
    if (nav_at_location && final_mag < tune_final_tol) begin
      cmd.achieved = was_armed;
      nav_armed    = 1'b0;
    end
    cmd.linear  = clamp_int32(lin);
    cmd.angular = clamp_int32(ang);
    cmd.active  = nav_armed;
    pending_commands.push_back(cmd);
  endfunction

  // ---------------------------------------------------------------------------
  // Stream and register port drivers
  // ---------------------------------------------------------------------------

  task automatic send_beat(input opcode_e op, input logic [31:0] x, input logic [31:0] y,
                           input logic [15:0] hdg);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {hdg, y, x};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_drive_command(op, x, y, hdg);
  endtask

  // Drops the input, waits for every queued command, then lets a step that
  // yields no result run out before the registers may change.
  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TURN_GAIN:   tune_turn_gain   = value[15:0];
      REG_DRIVE_GAIN:  tune_drive_gain  = value[15:0];
      REG_DIST_LEAVE:  tune_dist_leave  = value;
      REG_DIST_ARRIVE: tune_dist_arrive = value;
      REG_ANG_LEAVE:   tune_ang_leave   = value[14:0];
      REG_ANG_ARRIVE:  tune_ang_arrive  = value[14:0];
      REG_FINAL_TOL:   tune_final_tol   = value[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Writes all seven registers; unused upper bits carry junk that the block
  // must mask off.
  task automatic load_tuning(input logic [15:0] turn_gain, input logic [15:0] drive_gain,
                             input logic [31:0] dist_leave, input logic [31:0] dist_arrive,
                             input logic [14:0] ang_leave, input logic [14:0] ang_arrive,
                             input logic [14:0] final_tol);
    logic [31:0] junk;
    junk = $urandom;
    write_register(REG_TURN_GAIN,   {junk[31:16], turn_gain});
    write_register(REG_DRIVE_GAIN,  {junk[15:0], drive_gain});
    write_register(REG_DIST_LEAVE,  dist_leave);
    write_register(REG_DIST_ARRIVE, dist_arrive);
    write_register(REG_ANG_LEAVE,   {junk[31:15], ang_leave});
    write_register(REG_ANG_ARRIVE,  {junk[16:0], ang_arrive});
    write_register(REG_FINAL_TOL,   {~junk[16:0], final_tol});
  endtask

  // Any heading within plus or minus pi.
  function automatic logic [15:0] random_heading();
    return 16'(longint'($urandom_range(0, 2 * PiRad)) - PiRad);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long holds on request, and the checker
  // ---------------------------------------------------------------------------

  initial begin : command_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= no_idle || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PrintCap) begin
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : command_check
    drive_cmd_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_commands.size() == 0) begin
        report_mismatch("unexpected command beat", m_axis_tdata_o[31:0], 32'h0);
      end else begin
        want = pending_commands.pop_front();
        if (m_axis_tdata_o[31:0] !== want.linear) begin
          report_mismatch("linear_velocity", m_axis_tdata_o[31:0], want.linear);
        end
        if (m_axis_tdata_o[63:32] !== want.angular) begin
          report_mismatch("angular_velocity", m_axis_tdata_o[63:32], want.angular);
        end
        if (m_axis_tdata_o[64] !== want.active) begin
          report_mismatch("waypoint_active", {31'b0, m_axis_tdata_o[64]}, {31'b0, want.active});
        end
        if (m_axis_tdata_o[65] !== want.achieved) begin
          report_mismatch("target_achieved", {31'b0, m_axis_tdata_o[65]},
                          {31'b0, want.achieved});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases under the power-on tuning.
  task automatic test_directed_cases();
    // A step before any goal is dropped without a result.
    send_beat(OP_STEP, 32'h0, 32'h0, 16'h0);
    // Goal at the origin, step right on it: zero offset and instant arrival.
    send_beat(OP_SET_GOAL, 32'h0, 32'h0, 16'h0);
    send_beat(OP_STEP, 32'h0, 32'h0, 16'h0);
    // Disarmed: velocities stay zero and no second arrival is flagged.
    send_beat(OP_STEP, 32'h0, 32'h0, 16'sd200);
    // Extreme corners: saturating distances and headings past pi.
    send_beat(OP_SET_GOAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send_beat(OP_STEP, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    send_beat(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd25736);
    send_beat(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd25736);
    send_beat(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    // Bearing error exactly at pi, then one past it on either side.
    send_beat(OP_SET_GOAL, 32'h0001_0000, 32'h0, 16'sd25736);
    send_beat(OP_STEP, 32'h0, 32'h0, -16'sd25736);
    send_beat(OP_STEP, 32'h0, 32'h0, -16'sd25737);
    send_beat(OP_STEP, 32'h0, 32'h0, 16'sd25737);
    // Goal on the negative x side of the robot, straight and slightly below.
    send_beat(OP_STEP, 32'h0002_0000, 32'h0, 16'sd25736);
    send_beat(OP_STEP, 32'h0002_0000, 32'h1, 16'h0);
    // Drive in from far away, stop in the hysteresis band without turning,
    // then settle on the final heading.
    send_beat(OP_SET_GOAL, 32'h0, 32'h0, 16'h0);
    send_beat(OP_STEP, 32'h0064_0000, 32'h0, 16'sd25736);
    send_beat(OP_STEP, 32'd2500, 32'h0, 16'sd25736);
    send_beat(OP_STEP, 32'd100, 32'h0, 16'sd300);
    // Goal straight below: bearing of minus a quarter turn.
    send_beat(OP_SET_GOAL, 32'h0, 32'hFFFF_0000, 16'h0);
    send_beat(OP_STEP, 32'h0, 32'h0, 16'h0);
  endtask

  // Mostly goal-then-approach episodes, with some unrelated beats mixed in.
  task automatic run_navigation(input int unsigned beats);
    int unsigned     sent;
    int unsigned     steps;
    int unsigned     k;
    int unsigned     lo;
    int unsigned     mode;
    logic [31:0]     gx;
    logic [31:0]     gy;
    logic [31:0]     px;
    logic [31:0]     py;
    logic [31:0]     offx;
    logic [31:0]     offy;
    logic [15:0]     gh;
    logic [15:0]     hdg;
    longint unsigned span;
    longint          aim;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(99) < 12) begin
        send_beat(opcode_e'($urandom_range(1)), $urandom, $urandom, 16'($urandom));
        sent++;
      end else begin
        gx = $signed($urandom) >>> $urandom_range(0, 16);
        gy = $signed($urandom) >>> $urandom_range(0, 16);
        gh = random_heading();
        send_beat(OP_SET_GOAL, gx, gy, gh);
        sent++;
        steps = $urandom_range(2, 10);
        for (k = 0; k < steps; k++) begin
          // The offset to the goal tends to shrink as the episode goes on.
          lo   = (k * 3 > 31) ? 31 : k * 3;
          offx = $signed($urandom) >>> $urandom_range(lo, 31);
          offy = $signed($urandom) >>> $urandom_range(lo, 31);
          px   = gx - offx;
          py   = gy - offy;
          mode = $urandom_range(99);
          if (mode < 35) begin
            // Heading close to the bearing, so the robot gets to drive.
            cordic_vectoring(longint'($signed(gx)) - longint'($signed(px)),
                             longint'($signed(gy)) - longint'($signed(py)), span, aim);
            hdg = 16'(aim + int'($urandom_range(0, 1200)) - 600);
          end else if (mode < 60) begin
            hdg = gh + 16'(int'($urandom_range(0, 1200)) - 600);
          end else if (mode < 80) begin
            hdg = 16'($urandom);
          end else begin
            hdg = random_heading();
          end
          send_beat(OP_STEP, px, py, hdg);
          sent++;
        end
      end
    end
  endtask

  // Several tuning settings, extremes among them, each with a random run.
  task automatic test_random_navigation();
    settle_block();
    load_tuning(16'd5734, 16'd10813, 32'd3277, 32'd1966, 15'd1229, 15'd819, 15'd410);
    // Writes past the last register must change nothing.
    write_register(UnmappedReg, $urandom);
    run_navigation(140);

    settle_block();
    load_tuning(16'hFFFF, 16'hFFFF, 32'd3277, 32'd1966, 15'd1229, 15'd819, 15'd410);
    run_navigation(140);

    settle_block();
    load_tuning(16'h0, 16'h0, 32'd3277, 32'd1966, 15'd1229, 15'd819, 15'd410);
    run_navigation(140);

    settle_block();
    load_tuning(16'd5734, 16'd10813, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                15'h7FFF, 15'h7FFF, 15'h7FFF);
    run_navigation(140);

    // Zero thresholds, run without any idling on either side.
    settle_block();
    load_tuning(16'd5734, 16'd10813, 32'h0, 32'h0, 15'h0, 15'h0, 15'h0);
    no_idle <= 1'b1;
    run_navigation(140);
    no_idle <= 1'b0;

    repeat (2) begin
      settle_block();
      load_tuning(16'($urandom), 16'($urandom),
                  $urandom >> $urandom_range(0, 24), $urandom >> $urandom_range(0, 24),
                  15'($urandom_range(0, 32767) >> $urandom_range(0, 6)),
                  15'($urandom_range(0, 32767) >> $urandom_range(0, 6)),
                  15'($urandom_range(0, 32767) >> $urandom_range(0, 6)));
      run_navigation(140);
    end
  endtask

  // The result side holds off for a long stretch while steps keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    int unsigned k;
    settle_block();
    no_idle <= 1'b1;
    holds_requested <= holds_requested + 1;
    send_beat(OP_SET_GOAL, 32'h0010_0000, 32'hFFF0_0000, 16'sd1000);
    for (k = 0; k < 30; k++) begin
      send_beat(OP_STEP, $urandom >> $urandom_range(0, 31), $urandom, random_heading());
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_SET_GOAL;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    no_idle         <= 1'b0;
    restore_power_on_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_navigation();
    test_output_backpressure();

    settle_block();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ waypoint_turn_then_drive_controller_core.f @@
rtl/core/wtdc_pkg.sv
rtl/core/waypoint_turn_then_drive_controller_core.sv
tb/tb_top.sv
